### design/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;

    localparam logic [7:0] DIGIT_BASE = 8'd48;
    localparam logic [7:0] MINUS_CODE = 8'd45;

    // Number of decimal digits needed for a magnitude of up to 2**(bits-1).
    // The factor is log10(2) scaled by 100000.
    function automatic int num_digits(input int bits);
        return ((bits - 1) * 30103) / 100000 + 1;
    endfunction

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic digit_shift;
        logic show_sign;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_last;
        logic top_zero;
        logic digit_last;
        logic negative;
    } status_t;

endpackage

### design/sitda_datapath.sv
// ----------------------------------------------------------------------------
// sitda_datapath
// Magnitude register, shift-add-3 BCD converter and digit output shifter.
// ----------------------------------------------------------------------------
module sitda_datapath #(
    parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [VALUE_BITS-1:0]    value,
    input  sitda_pkg::cmd_t          cmd,
    output sitda_pkg::status_t       sts,
    output logic [7:0]               character,
    output logic                     last
);

    localparam int NDIG = sitda_pkg::num_digits(VALUE_BITS);
    localparam int BCD_BITS = 4 * NDIG;
    localparam int BCW = $clog2(VALUE_BITS + 1);
    localparam int DCW = $clog2(NDIG + 1);

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BCD_BITS-1:0]   bcd_reg, bcd_next;
    logic [BCD_BITS-1:0]   bcd_adj;
    logic                  neg_reg, neg_next;
    logic [BCW-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [DCW-1:0]        dig_cnt_reg, dig_cnt_next;
    logic [3:0]            top_digit;

    // Add three to every digit of five or more before the next shift.
    always_comb
    begin
        logic [3:0] d;
        bcd_adj = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            d = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
        end
    end

    always_comb
    begin
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        if (cmd.load)
        begin
            neg_next     = value[VALUE_BITS-1];
            mag_next     = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
            bcd_next     = '0;
            bit_cnt_next = BCW'(VALUE_BITS);
            dig_cnt_next = DCW'(NDIG);
        end
        else if (cmd.step)
        begin
            bcd_next     = {bcd_adj[BCD_BITS-2:0], mag_reg[VALUE_BITS-1]};
            mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - BCW'(1);
        end
        else if (cmd.digit_shift)
        begin
            bcd_next     = {bcd_reg[BCD_BITS-5:0], 4'd0};
            dig_cnt_next = dig_cnt_reg - DCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            neg_reg     <= 1'b0;
        end
        else
        begin
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            neg_reg     <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[BCD_BITS-1 -: 4];

    assign sts.conv_last  = (bit_cnt_reg == BCW'(1));
    assign sts.top_zero   = (top_digit == 4'd0);
    assign sts.digit_last = (dig_cnt_reg == DCW'(1));
    assign sts.negative   = neg_reg;

    assign character = cmd.show_sign ? sitda_pkg::MINUS_CODE
                                     : (sitda_pkg::DIGIT_BASE + {4'd0, top_digit});
    assign last      = !cmd.show_sign && sts.digit_last;

endmodule

### design/sitda_ctrl.sv
// ----------------------------------------------------------------------------
// sitda_ctrl
// Controller that sequences load, conversion, zero skipping and emission.
// ----------------------------------------------------------------------------
module sitda_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 value_valid,
    output logic                 value_ready,
    output logic                 char_valid,
    input  logic                 char_ready,
    input  sitda_pkg::status_t   sts,
    output sitda_pkg::cmd_t      cmd
);

    sitda_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sitda_pkg::ST_IDLE:
                if (value_valid)
                    state_next = sitda_pkg::ST_CONVERT;
            sitda_pkg::ST_CONVERT:
                if (sts.conv_last)
                    state_next = sitda_pkg::ST_SKIP;
            sitda_pkg::ST_SKIP:
                if (!(sts.top_zero && !sts.digit_last))
                    state_next = sts.negative ? sitda_pkg::ST_SIGN : sitda_pkg::ST_DIGIT;
            sitda_pkg::ST_SIGN:
                if (char_ready)
                    state_next = sitda_pkg::ST_DIGIT;
            sitda_pkg::ST_DIGIT:
                if (char_ready && sts.digit_last)
                    state_next = sitda_pkg::ST_IDLE;
            default:
                state_next = sitda_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        value_ready = 1'b0;
        char_valid  = 1'b0;
        case (state_reg)
            sitda_pkg::ST_IDLE:
            begin
                value_ready = 1'b1;
                cmd.load    = value_valid;
            end
            sitda_pkg::ST_CONVERT:
                cmd.step = 1'b1;
            sitda_pkg::ST_SKIP:
                cmd.digit_shift = sts.top_zero && !sts.digit_last;
            sitda_pkg::ST_SIGN:
            begin
                char_valid    = 1'b1;
                cmd.show_sign = 1'b1;
            end
            sitda_pkg::ST_DIGIT:
            begin
                char_valid      = 1'b1;
                cmd.digit_shift = char_ready && !sts.digit_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sitda_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### design/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a two's complement integer into its decimal ASCII characters.
// ----------------------------------------------------------------------------
// Each accepted value is sent out as its decimal text, most significant
// character first: a minus sign for a negative value, then the digits with
// leading zeros removed, so zero gives the single character '0'. The most
// negative value converts exactly. The final character of every number has
// last set. One value is handled at a time: value_ready is high only while
// the block is idle. A transaction loads the value, runs the shift-add-3
// conversion in the BCD register once per magnitude bit, drops each
// suppressed leading zero in turn, makes one decision step, then sends one
// character at a time, holding each while char_ready is low. The
// shift-add-3 loop is the longest of these steps.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  value_valid,
    output logic                  value_ready,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  char_valid,
    input  logic                  char_ready,
    output logic [7:0]            character,
    output logic                  last
);

    sitda_pkg::cmd_t    cmd;
    sitda_pkg::status_t sts;

    // The controller owns both handshakes; the datapath holds every value.
    sitda_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    // The datapath presents the character from registers, so it stays
    // stable while a transaction on the output waits for char_ready.
    sitda_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .sts       (sts),
        .character (character),
        .last      (last)
    );

    // Input and output never handshake in the same cycle.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(value_ready && char_valid))
        else $error("input and output active together");

    // After a value is taken, no further value is taken next cycle.
    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (value_valid && value_ready) |=> !value_ready)
        else $error("block not busy after load");

    // The final character returns the block to idle.
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_ready && last) |=> value_ready)
        else $error("block not idle after last character");

    // Only a minus sign or a digit is ever offered.
    a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (character == sitda_pkg::MINUS_CODE ||
                        (character >= sitda_pkg::DIGIT_BASE &&
                         character <= sitda_pkg::DIGIT_BASE + 8'd9)))
        else $error("bad character code");

endmodule

### sim/signed_int_to_decimal_ascii_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// Self-checking bench for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
// Values go in on the value channel and every character that comes back on
// the character channel is checked against a predicted decimal string. The
// run covers the range extremes, zero, the most negative value and all
// digit counts but four, then a few hundred random values. Both channels
// idle at random, with one long stretch where they run flat out.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;

    localparam int VALUE_BITS      = 32;
    localparam int RANDOM_VALUES   = 353;
    localparam int IDLE_PERCENT    = 8;
    // Cycles with no transaction on either channel before the run is
    // declared hung.
    localparam int WATCHDOG_LIMIT  = 1000;
    // Quiet cycles after the last character, to catch stray output.
    localparam int TAIL_CYCLES     = 64;
    localparam int REPORT_LIMIT    = 10;

    // One expected character of the decimal text.
    typedef struct packed {
        logic [7:0] code;
        logic       is_last;
    } text_char_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  value_valid = 1'b0;
    logic                  value_ready;
    logic [VALUE_BITS-1:0] value = '0;
    logic                  char_valid;
    logic                  char_ready = 1'b0;
    logic [7:0]            character;
    logic                  last;

    // Characters still owed by the block, oldest first.
    text_char_t pending_text[$];
    text_char_t next_char;
    int         error_count = 0;
    int         idle_cycles = 0;
    // While set, neither side idles, so back to back transactions are seen.
    logic       no_idle_stretch = 1'b0;

    signed_int_to_decimal_ascii #(
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .value       (value),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .character   (character),
        .last        (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Counts a failure and prints the first few of them in full.
    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
        begin
            $display("%0t ERROR: %s", $realtime, msg);
        end
    endtask

    // Builds the decimal text of one value and queues it. The magnitude is
    // formed in unsigned arithmetic so the most negative value is exact.
    function automatic void predict_text(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] magnitude;
        logic [3:0]            digits[0:19];
        int                    count;
        logic                  negative;
        text_char_t            item;

        negative  = v[VALUE_BITS-1];
        magnitude = negative ? (~v + VALUE_BITS'(1)) : v;
        count     = 0;
        // Digits come out least significant first.
        do
        begin
            digits[count] = 4'(magnitude % 10);
            count++;
            magnitude = magnitude / 10;
        end
        while (magnitude != 0);

        if (negative)
        begin
            item.code    = sitda_pkg::MINUS_CODE;
            item.is_last = 1'b0;
            pending_text = {pending_text, item};
        end
        for (int i = count - 1; i >= 0; i--)
        begin
            item.code    = sitda_pkg::DIGIT_BASE + {4'd0, digits[i]};
            item.is_last = (i == 0);
            pending_text = {pending_text, item};
        end
    endfunction

    // Presents one value and returns at the edge where it is accepted.
    // Valid stays high on return, so a following call that does not idle
    // keeps the channel busy without a gap.
    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        if (!no_idle_stretch && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            value_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        value_valid <= 1'b1;
        value       <= v;
        do
        begin
            @(posedge clk);
        end
        while (!value_ready);
        predict_text(v);
    endtask

    // Receiver side: stalls at random except during the flat-out stretch.
    always @(posedge clk)
    begin
        char_ready <= no_idle_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Compares every accepted character with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && char_valid && char_ready)
        begin
            if (pending_text.size() == 0)
            begin
                note_error($sformatf("unexpected character 0x%02h last=%0b",
                                     character, last));
            end
            else
            begin
                next_char = pending_text.pop_front();
                if (character !== next_char.code || last !== next_char.is_last)
                begin
                    note_error($sformatf("character 0x%02h last=%0b, expected 0x%02h last=%0b",
                                         character, last, next_char.code,
                                         next_char.is_last));
                end
            end
        end
    end

    // Ends the run if neither channel moves for too long.
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((value_valid && value_ready) || (char_valid && char_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("%0t watchdog: no transaction for %0d cycles", $realtime,
                 WATCHDOG_LIMIT);
        $display("signed_int_to_decimal_ascii_tb: done, errors");
        $finish;
    end

    // Range extremes, zero, the most negative value, and values of every digit
    // count but four, several at the edges of a count and with both signs.
    task automatic test_directed_values();
        send_value(32'sd0);
        send_value(32'sd1);
        send_value(-32'sd1);
        send_value(32'sd9);
        send_value(32'sd10);
        send_value(-32'sd10);
        send_value(32'sd99);
        send_value(-32'sd100);
        send_value(32'sd12345);
        send_value(-32'sd987654);
        send_value(32'sd1000000);
        send_value(32'sd99999999);
        send_value(-32'sd100000000);
        send_value(32'sd999999999);
        send_value(-32'sd999999999);
        send_value(32'sd1000000000);
        send_value(-32'sd1000000000);
        send_value(32'sd2147483647);
        send_value(-32'sd2147483647);
        // The most negative value has no positive counterpart.
        send_value(32'h8000_0000);
        send_value(32'sd1234567890);
        send_value(32'h5555_5555);
        send_value(32'hAAAA_AAAA);
    endtask

    // The sender holds off until the block has delivered every character,
    // then resumes from a fully idle block.
    task automatic test_drain_then_resume();
        send_value(-32'sd42);
        send_value(32'sd7);
        value_valid <= 1'b0;
        while (pending_text.size() != 0)
        begin
            @(posedge clk);
        end
        send_value(32'sd2000000000);
        send_value(-32'sd5);
    endtask

    // Random values: a mix of full-range words, values of a chosen digit
    // count, and values next to a power of ten.
    task automatic test_random_values();
        longint lo;
        longint hi;
        longint magnitude;
        longint power;
        int     pick;
        int     len;
        logic   negative;

        for (int n = 0; n < RANDOM_VALUES; n++)
        begin
            // A long run without idling on either side.
            no_idle_stretch = (n >= 150 && n < 250);
            pick     = $urandom_range(0, 99);
            negative = 1'($urandom_range(0, 1));
            if (pick < 40)
            begin
                send_value(VALUE_BITS'($urandom));
            end
            else if (pick < 85)
            begin
                len = $urandom_range(1, 10);
                lo  = 1;
                for (int k = 1; k < len; k++)
                begin
                    lo = lo * 10;
                end
                hi = lo * 10 - 1;
                if (len == 1)
                begin
                    lo = 0;
                end
                if (hi > 64'sd2147483647)
                begin
                    hi = negative ? 64'sd2147483648 : 64'sd2147483647;
                end
                magnitude = lo + longint'($urandom_range(0, 32'(hi - lo)));
                send_value(VALUE_BITS'(negative ? -magnitude : magnitude));
            end
            else
            begin
                power = 1;
                repeat ($urandom_range(0, 9)) power = power * 10;
                magnitude = power + $urandom_range(0, 2) - 1;
                send_value(VALUE_BITS'(negative ? -magnitude : magnitude));
            end
        end
        no_idle_stretch = 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_values();
        test_drain_then_resume();
        test_random_values();

        value_valid <= 1'b0;
        while (pending_text.size() != 0)
        begin
            @(posedge clk);
        end
        // Stay a while longer so that any extra character gets flagged.
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("signed_int_to_decimal_ascii_tb: done, clean");
        end
        else
        begin
            $display("signed_int_to_decimal_ascii_tb: done, errors");
        end
        $finish;
    end

endmodule

### filelist.f
design/sitda_pkg.sv
design/sitda_datapath.sv
design/sitda_ctrl.sv
design/signed_int_to_decimal_ascii.sv
sim/signed_int_to_decimal_ascii_tb.sv
